// ----- design/dhd_pkg.sv -----
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types, constants and the minimum payload length table for the
// DoIP header deframer.
// ----------------------------------------------------------------------------
package dhd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 1;
    localparam int MIN_LEN_W    = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_VERSION    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERATE_VERSION = 2'd1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TOO_SMALL   = 2'd1;
    localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;
    localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd3;

    localparam int POS_VERSION = 0;
    localparam int POS_INVERSE = 1;
    localparam int POS_TYPE_HI = 2;
    localparam int POS_TYPE_LO = 3;
    localparam int POS_LEN_3   = 4;
    localparam int POS_LEN_2   = 5;
    localparam int POS_LEN_1   = 6;
    localparam int POS_LEN_0   = 7;

    localparam logic [15:0] TYPE_NACK          = 16'h0000;
    localparam logic [15:0] TYPE_VEH_ANNOUNCE  = 16'h0004;
    localparam logic [15:0] TYPE_ROUTE_REQ     = 16'h0005;
    localparam logic [15:0] TYPE_ROUTE_RSP     = 16'h0006;
    localparam logic [15:0] TYPE_ALIVE_RSP     = 16'h0008;
    localparam logic [15:0] TYPE_ENTITY_STATUS = 16'h4002;
    localparam logic [15:0] TYPE_POWER_MODE    = 16'h4004;
    localparam logic [15:0] TYPE_DIAG_MSG      = 16'h8001;
    localparam logic [15:0] TYPE_DIAG_ACK      = 16'h8002;
    localparam logic [15:0] TYPE_DIAG_NACK     = 16'h8003;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in_req;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  payload_out;
        logic        verdict_valid;
        logic [1:0]  status;
        logic [7:0]  proto_version;
        logic [7:0]  inv_version;
        logic [15:0] type_code;
        logic [31:0] length_field;
    } t_out_req;

    typedef struct packed {
        logic check_version;
        logic tolerate_bad_version;
    } t_cfg;

    function automatic logic [MIN_LEN_W-1:0] min_payload(input logic [15:0] type_code);
        logic [MIN_LEN_W-1:0] len;
        case (type_code)
            TYPE_NACK:          len = 6'd3;
            TYPE_VEH_ANNOUNCE:  len = 6'd32;
            TYPE_ROUTE_REQ:     len = 6'd7;
            TYPE_ROUTE_RSP:     len = 6'd9;
            TYPE_ALIVE_RSP:     len = 6'd2;
            TYPE_ENTITY_STATUS: len = 6'd5;
            TYPE_POWER_MODE:    len = 6'd1;
            TYPE_DIAG_MSG:      len = 6'd4;
            TYPE_DIAG_ACK:      len = 6'd3;
            TYPE_DIAG_NACK:     len = 6'd3;
            default:            len = 6'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- design/dhd_in_stage.sv -----
// ----------------------------------------------------------------------------
// dhd_in_stage
// Input register: holds one accepted request until the parser takes it.
// ----------------------------------------------------------------------------
module dhd_in_stage
    import dhd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_in_req i_req,
    output logic    o_stall,
    output logic    o_valid,
    output t_in_req o_req,
    input  logic    i_take
);

    logic    r_valid;
    logic    n_valid;
    t_in_req r_req;
    logic    accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- design/dhd_parser.sv -----
// ----------------------------------------------------------------------------
// dhd_parser
// Header gathering, checks, payload countdown and discard; one request per
// cycle when fired.
// ----------------------------------------------------------------------------
module dhd_parser
    import dhd_pkg::*;
#(
    parameter int HeaderBytes = HEADER_BYTES
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_req  i_req,
    input  t_cfg     i_cfg,
    output logic     o_result_valid,
    output t_out_req o_result
);

    localparam int IdxW = $clog2(HeaderBytes + 1);
    localparam logic [IdxW-1:0] LastIdx    = IdxW'(HeaderBytes - 1);
    localparam logic [IdxW-1:0] PayloadIdx = IdxW'(HeaderBytes);

    logic [IdxW-1:0] r_index,     n_index;
    logic [7:0]      r_version,   n_version;
    logic [7:0]      r_inverse,   n_inverse;
    logic [15:0]     r_type,      n_type;
    logic [31:0]     r_length,    n_length;
    logic [31:0]     r_remaining, n_remaining;
    logic            r_short,     n_short;
    logic            r_discard,   n_discard;

    logic       verdict;
    logic [1:0] verdict_status;
    logic       verdict_error;
    logic       bad_version;
    logic       too_short;
    logic [7:0] b;
    logic       fin;

    always_comb begin
        b              = i_req.in_byte;
        fin            = i_req.buffer_end;
        n_index        = r_index;
        n_version      = r_version;
        n_inverse      = r_inverse;
        n_type         = r_type;
        n_length       = r_length;
        n_remaining    = r_remaining;
        n_short        = r_short;
        n_discard      = r_discard;
        verdict        = 1'b0;
        verdict_status = STATUS_OK;
        verdict_error  = 1'b0;
        bad_version    = 1'b0;
        too_short      = 1'b0;
        o_result_valid = 1'b0;
        o_result       = '0;

        if (r_discard) begin
            if (fin) begin
                n_discard = 1'b0;
                n_index   = '0;
            end
        end else if (r_index < PayloadIdx) begin
            if (r_index == '0) begin
                n_version = '0;
                n_inverse = '0;
                n_type    = '0;
                n_length  = '0;
            end
            case (r_index)
                IdxW'(POS_VERSION): n_version       = b;
                IdxW'(POS_INVERSE): n_inverse       = b;
                IdxW'(POS_TYPE_HI): n_type[15:8]    = b;
                IdxW'(POS_TYPE_LO): n_type[7:0]     = b;
                IdxW'(POS_LEN_3):   n_length[31:24] = b;
                IdxW'(POS_LEN_2):   n_length[23:16] = b;
                IdxW'(POS_LEN_1):   n_length[15:8]  = b;
                IdxW'(POS_LEN_0):   n_length[7:0]   = b;
                default: ;
            endcase
            n_index = r_index + 1'b1;

            if (r_index != LastIdx) begin
                if (fin) begin
                    verdict        = 1'b1;
                    verdict_status = STATUS_TOO_SMALL;
                    verdict_error  = 1'b1;
                end
            end else begin
                bad_version = i_cfg.check_version && ((n_version ^ n_inverse) != 8'hFF)
                              && !i_cfg.tolerate_bad_version;
                too_short   = n_length < 32'(min_payload(n_type));
                if (bad_version) begin
                    verdict        = 1'b1;
                    verdict_status = STATUS_BAD_VERSION;
                    verdict_error  = 1'b1;
                end else begin
                    n_short = too_short;
                    if (n_length == '0) begin
                        verdict        = 1'b1;
                        verdict_status = too_short ? STATUS_BAD_LENGTH : STATUS_OK;
                        verdict_error  = too_short;
                    end else if (fin) begin
                        verdict        = 1'b1;
                        verdict_status = STATUS_TOO_SMALL;
                        verdict_error  = 1'b1;
                    end else begin
                        n_remaining = n_length;
                    end
                end
            end
        end else begin
            o_result_valid       = 1'b1;
            o_result.data_valid  = 1'b1;
            o_result.payload_out = b;
            n_remaining          = r_remaining - 1'b1;
            if (r_remaining == 32'd1) begin
                verdict        = 1'b1;
                verdict_status = r_short ? STATUS_BAD_LENGTH : STATUS_OK;
                verdict_error  = r_short;
            end else if (fin) begin
                verdict        = 1'b1;
                verdict_status = STATUS_TOO_SMALL;
                verdict_error  = 1'b1;
            end
        end

        if (verdict) begin
            o_result_valid         = 1'b1;
            o_result.verdict_valid = 1'b1;
            o_result.status        = verdict_status;
            o_result.proto_version = n_version;
            o_result.inv_version   = n_inverse;
            o_result.type_code     = n_type;
            o_result.length_field  = n_length;
            n_index                = '0;
            n_discard              = verdict_error && !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_discard <= 1'b0;
            r_short   <= 1'b0;
        end else if (i_fire) begin
            r_index   <= n_index;
            r_discard <= n_discard;
            r_short   <= n_short;
        end
        if (i_fire) begin
            r_version   <= n_version;
            r_inverse   <= n_inverse;
            r_type      <= n_type;
            r_length    <= n_length;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ----- design/dhd_out_stage.sv -----
// ----------------------------------------------------------------------------
// dhd_out_stage
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module dhd_out_stage
    import dhd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_out_req i_req,
    output logic     o_free,
    output logic     o_valid,
    output t_out_req o_req,
    input  logic     i_stall
);

    logic     r_valid;
    logic     n_valid;
    t_out_req r_req;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- design/doip_header_deframer.sv -----
// ----------------------------------------------------------------------------
// doip_header_deframer
// Splits a byte stream into DoIP messages: header capture, checks, payload
// forwarding and one verdict per message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / i_in_req / o_in_stall carries one byte per
//   request with a buffer-end flag on the last byte of a received buffer.
//   Output channel o_out_valid / o_out_req / i_out_stall carries at most one
//   result request per byte: a forwarded payload byte, a verdict, or both.
//   Header bytes without a verdict and discarded bytes give no result.
//   A byte accepted into the input register is parsed by the combinational
//   parse step and its result is then loaded into the result register.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the combinational parse step between the two registers.
//   Receiver stall holds the result register; the parse step then waits and
//   the input register fills, after which o_in_stall rises.
//   Reset: awaiting the first header byte, not discarding, version check
//   enabled, bad versions rejected. Write i_cfg_* only while idle.
// ----------------------------------------------------------------------------
module doip_header_deframer
    import dhd_pkg::*;
#(
    parameter int HeaderBytes = HEADER_BYTES
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  t_in_req                i_in_req,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out_req               o_out_req,
    input  logic                   i_out_stall,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg     r_cfg;
    logic     pend_valid;
    t_in_req  pend_req;
    logic     out_free;
    logic     fire;
    logic     result_valid;
    t_out_req result;

    assign fire = pend_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_version        <= 1'b1;
            r_cfg.tolerate_bad_version <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_VERSION:    r_cfg.check_version        <= i_cfg_wdata[0];
                CFG_TOLERATE_VERSION: r_cfg.tolerate_bad_version <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dhd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_stall (o_in_stall),
        .o_valid (pend_valid),
        .o_req   (pend_req),
        .i_take  (fire)
    );

    dhd_parser #(
        .HeaderBytes (HeaderBytes)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_req          (pend_req),
        .i_cfg          (r_cfg),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    dhd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && result_valid),
        .i_req   (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_req   (o_out_req),
        .i_stall (i_out_stall)
    );

endmodule
